// File: src/frcd_pkg.sv
package frcd_pkg;

    localparam int unsigned FieldW  = 32;
    localparam int unsigned DenOutW = 31;
    localparam int unsigned StatusW = 2;

    localparam logic [StatusW-1:0] StatusOk       = 2'd0;
    localparam logic [StatusW-1:0] StatusZeroDen  = 2'd1;
    localparam logic [StatusW-1:0] StatusOverflow = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GCD   = 9'b000000010,
        S_DIV1  = 9'b000000100,
        S_DIV2  = 9'b000001000,
        S_LCM   = 9'b000010000,
        S_DIV3  = 9'b000100000,
        S_DIV4  = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic gcd_start;
        logic div_start;
        logic [2:0] div_sel;
        logic lcm_start;
        logic scale_start;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic early;
        logic mode;
        logic unit_done;
    } t_stat;

    localparam logic [2:0] DivGcdNa = 3'd0;
    localparam logic [2:0] DivGcdDa = 3'd1;
    localparam logic [2:0] DivLcmDa = 3'd2;
    localparam logic [2:0] DivLcmDb = 3'd3;

endpackage

// File: src/frcd_ctrl.sv
module frcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  frcd_pkg::t_stat i_stat,
    output frcd_pkg::t_cmd  o_cmd
);

    frcd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != frcd_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            frcd_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = frcd_pkg::S_GCD;
                end
            end
            frcd_pkg::S_GCD: begin
                if (i_stat.early) begin
                    n_state = frcd_pkg::S_DONE;
                end else begin
                    o_cmd.gcd_start = 1'b1;
                    n_state         = frcd_pkg::S_DIV1;
                end
            end
            frcd_pkg::S_DIV1: begin
                // wait gcd, then first divide
                if (i_stat.unit_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = i_stat.mode ? frcd_pkg::DivLcmDa : frcd_pkg::DivGcdNa;
                    n_state         = i_stat.mode ? frcd_pkg::S_LCM : frcd_pkg::S_DIV2;
                end
            end
            frcd_pkg::S_DIV2: begin
                if (i_stat.unit_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = frcd_pkg::DivGcdDa;
                    n_state         = frcd_pkg::S_DIV4;
                end
            end
            frcd_pkg::S_LCM: begin
                if (i_stat.unit_done) begin
                    o_cmd.lcm_start = 1'b1;
                    n_state         = frcd_pkg::S_DIV3;
                end
            end
            frcd_pkg::S_DIV3: begin
                if (i_stat.unit_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = frcd_pkg::DivLcmDa;
                    n_state         = frcd_pkg::S_DIV4;
                end
            end
            frcd_pkg::S_DIV4: begin
                if (i_stat.unit_done) begin
                    if (i_stat.mode) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcd_pkg::DivLcmDb;
                    end
                    n_state = frcd_pkg::S_SCALE;
                end
            end
            frcd_pkg::S_SCALE: begin
                if (i_stat.unit_done) begin
                    o_cmd.scale_start = i_stat.mode;
                    n_state           = frcd_pkg::S_DONE;
                end
            end
            frcd_pkg::S_DONE: begin
                if (i_stat.unit_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = frcd_pkg::S_IDLE;
                end
            end
            default: n_state = frcd_pkg::S_IDLE;
        endcase
    end

endmodule

// File: src/frcd_dp.sv
module frcd_dp #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  frcd_pkg::t_cmd                   i_cmd,
    output frcd_pkg::t_stat                  o_stat,
    input  logic                             i_mode,
    input  logic signed [frcd_pkg::FieldW-1:0] i_num_a,
    input  logic signed [frcd_pkg::FieldW-1:0] i_den_a,
    input  logic signed [frcd_pkg::FieldW-1:0] i_num_b,
    input  logic signed [frcd_pkg::FieldW-1:0] i_den_b,
    output logic                             o_done,
    output logic signed [frcd_pkg::FieldW-1:0] o_out_num_a,
    output logic [frcd_pkg::DenOutW-1:0]     o_out_den_a,
    output logic signed [frcd_pkg::FieldW-1:0] o_out_num_b,
    output logic [frcd_pkg::DenOutW-1:0]     o_out_den_b,
    output logic [frcd_pkg::StatusW-1:0]     o_status
);

    localparam int unsigned MW  = 33;          // magnitudes up to 2^31
    localparam int unsigned PW  = 2 * MW;      // product width
    localparam int unsigned CW  = $clog2(PW + 1);
    localparam logic [PW-1:0] PosLim = (PW'(1) << (WIDTH - 1)) - PW'(1);

    function automatic logic [MW-1:0] mag(input logic [frcd_pkg::FieldW-1:0] v);
        logic [MW-1:0] e;
        e = {1'b0, v};
        return v[frcd_pkg::FieldW-1] ? (MW'(33'h1_0000_0000) - e) : e;
    endfunction

    logic          r_mode, r_nega, r_negb, r_early;
    logic [1:0]    r_stat_early;
    logic [MW-1:0] r_na, r_da, r_nb, r_db;
    // gcd unit
    logic [MW-1:0] r_gb;
    logic          r_gcd_busy;
    // shift-subtract divider (quotient wide enough for products)
    logic [PW-1:0] r_rem, r_quo, r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_div_busy, r_div_gcd;
    logic [2:0]    r_div_sel;
    logic [PW-1:0] r_ra_n, r_ra_d, r_rb_n, r_lcm, r_fa, r_fb;
    // shift-add multiplier
    logic [PW-1:0] r_macc, r_mcand;
    logic [MW-1:0] r_mplier;
    logic [CW-1:0] r_mcnt;
    logic          r_mul_busy, r_mul_lcm, r_mul_b;
    logic          r_done;

    logic [PW-1:0] w_rem_sh, w_rem_sub, w_quo_nx;
    logic          w_rem_ge;
    logic          w_fit;

    assign o_stat.early     = r_early;
    assign o_stat.mode      = r_mode;
    assign o_stat.unit_done = !r_gcd_busy && !r_div_busy && !r_mul_busy;

    assign w_rem_sh  = {r_rem[PW-2:0], r_quo[PW-1]};
    assign w_rem_sub = w_rem_sh - r_dvs;
    assign w_rem_ge  = (w_rem_sh >= r_dvs);
    assign w_quo_nx  = {r_quo[PW-2:0], w_rem_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcd_busy <= 1'b0;
            r_div_busy <= 1'b0;
            r_mul_busy <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load) begin
                r_mode  <= i_mode;
                r_na    <= mag(i_num_a);
                r_da    <= mag(i_den_a);
                r_nb    <= mag(i_num_b);
                r_db    <= mag(i_den_b);
                r_nega  <= (i_num_a[frcd_pkg::FieldW-1] != i_den_a[frcd_pkg::FieldW-1])
                           && (i_num_a != '0);
                r_negb  <= (i_num_b[frcd_pkg::FieldW-1] != i_den_b[frcd_pkg::FieldW-1])
                           && (i_num_b != '0);
                // zero denominator, or mode 0 zero numerator: no iteration
                r_early <= (i_den_a == '0) || (i_mode && (i_den_b == '0))
                           || (!i_mode && (i_num_a == '0));
                r_stat_early <= ((i_den_a == '0) || (i_mode && (i_den_b == '0)))
                                ? 2'd1 : 2'd0;
                r_ra_n <= PW'(mag(i_num_a));
                r_ra_d <= PW'(mag(i_den_a));
                r_rb_n <= '0;
                r_lcm  <= '0;
            end
            // gcd remainders run MW steps with the dividend parked in the upper half
            if (i_cmd.gcd_start) begin
                r_gb       <= r_mode ? r_db : r_da;
                r_gcd_busy <= 1'b1;
                r_div_busy <= 1'b1;
                r_div_gcd  <= 1'b1;
                r_rem      <= '0;
                r_quo      <= {(r_mode ? r_da : r_na), MW'(0)};
                r_dvs      <= PW'(r_mode ? r_db : r_da);
                r_cnt      <= CW'(MW);
            end else if (r_gcd_busy && !r_div_busy) begin
                // remainder ready in r_rem: step euclid
                if (r_rem == '0) begin
                    r_gcd_busy <= 1'b0;
                end else begin
                    r_gb       <= MW'(r_rem);
                    r_div_busy <= 1'b1;
                    r_rem      <= '0;
                    r_quo      <= {r_gb, MW'(0)};
                    r_dvs      <= r_rem;
                    r_cnt      <= CW'(MW);
                end
            end
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_gcd  <= 1'b0;
                r_div_sel  <= i_cmd.div_sel;
                r_rem      <= '0;
                r_cnt      <= CW'(PW);
                case (i_cmd.div_sel)
                    frcd_pkg::DivGcdNa: begin r_quo <= PW'(r_na); r_dvs <= PW'(r_gb); end
                    frcd_pkg::DivGcdDa: begin r_quo <= PW'(r_da); r_dvs <= PW'(r_gb); end
                    frcd_pkg::DivLcmDa: begin
                        // first use: da/g ; later: lcm/da
                        r_quo <= (r_lcm == '0) ? PW'(r_da) : r_lcm;
                        r_dvs <= (r_lcm == '0) ? PW'(r_gb) : PW'(r_da);
                    end
                    frcd_pkg::DivLcmDb: begin r_quo <= r_lcm; r_dvs <= PW'(r_db); end
                    default: begin r_quo <= '0; r_dvs <= PW'(1); end
                endcase
            end else if (r_div_busy) begin
                r_rem <= w_rem_ge ? w_rem_sub : w_rem_sh;
                r_quo <= w_quo_nx;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_div_busy <= 1'b0;
                    // a plain divide drops its quotient straight into place
                    if (!r_div_gcd) begin
                        case (r_div_sel)
                            frcd_pkg::DivGcdNa: r_ra_n <= w_quo_nx;
                            frcd_pkg::DivGcdDa: r_ra_d <= w_quo_nx;
                            frcd_pkg::DivLcmDa: r_fa   <= w_quo_nx;
                            frcd_pkg::DivLcmDb: r_fb   <= w_quo_nx;
                            default: ;
                        endcase
                    end
                end
            end
            if (i_cmd.lcm_start) begin
                // lcm = (da/g) * db
                r_mul_busy <= 1'b1;
                r_mul_lcm  <= 1'b1;
                r_mul_b    <= 1'b0;
                r_macc     <= '0;
                r_mcand    <= r_fa;
                r_mplier   <= r_db;
                r_mcnt     <= CW'(MW);
            end else if (i_cmd.scale_start) begin
                r_mul_busy <= 1'b1;
                r_mul_lcm  <= 1'b0;
                r_mul_b    <= 1'b0;
                r_macc     <= '0;
                r_mcand    <= r_fa;
                r_mplier   <= r_na;
                r_mcnt     <= CW'(MW);
            end else if (r_mul_busy) begin
                if (r_mplier[0]) begin
                    r_macc <= r_macc + r_mcand;
                end
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                r_mcnt   <= r_mcnt - CW'(1);
                if (r_mcnt == CW'(1)) begin
                    if (r_mul_lcm) begin
                        r_mul_busy <= 1'b0;
                    end else if (!r_mul_b) begin
                        r_mul_b  <= 1'b1;
                        r_mcand  <= r_fb;
                        r_mplier <= r_nb;
                        r_mcnt   <= CW'(MW);
                        r_macc   <= '0;
                    end else begin
                        r_mul_busy <= 1'b0;
                    end
                end
            end
            if (r_mul_busy && r_mcnt == CW'(1)) begin
                if (r_mul_lcm) begin
                    r_lcm  <= r_mplier[0] ? r_macc + r_mcand : r_macc;
                end else if (!r_mul_b) begin
                    r_ra_n <= r_mplier[0] ? r_macc + r_mcand : r_macc;
                end else begin
                    r_rb_n <= r_mplier[0] ? r_macc + r_mcand : r_macc;
                    r_ra_d <= r_lcm;
                end
            end
        end
    end

    always_comb begin
        w_fit = (r_nega ? (r_ra_n <= PosLim + PW'(1)) : (r_ra_n <= PosLim))
                && (r_ra_d <= PosLim);
        if (r_mode) begin
            w_fit = w_fit && (r_negb ? (r_rb_n <= PosLim + PW'(1)) : (r_rb_n <= PosLim));
        end
    end

    logic [PW-1:0] w_na_s, w_nb_s;
    assign w_na_s = r_nega ? (PW'(0) - r_ra_n) : r_ra_n;
    assign w_nb_s = r_negb ? (PW'(0) - r_rb_n) : r_rb_n;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_stat_early == 2'd1) begin
                o_status    <= frcd_pkg::StatusZeroDen;
                o_out_num_a <= '0; o_out_den_a <= '0;
                o_out_num_b <= '0; o_out_den_b <= '0;
            end else if (!w_fit) begin
                o_status    <= frcd_pkg::StatusOverflow;
                o_out_num_a <= '0; o_out_den_a <= '0;
                o_out_num_b <= '0; o_out_den_b <= '0;
            end else begin
                o_status    <= frcd_pkg::StatusOk;
                o_out_num_a <= w_na_s[frcd_pkg::FieldW-1:0];
                o_out_den_a <= r_ra_d[frcd_pkg::DenOutW-1:0];
                o_out_num_b <= r_mode ? w_nb_s[frcd_pkg::FieldW-1:0] : '0;
                o_out_den_b <= r_mode ? r_ra_d[frcd_pkg::DenOutW-1:0] : '0;
            end
        end
    end

    assign o_done = r_done;

endmodule

// File: src/fraction_reduce_common_denominator.sv
// flow: on a zero denominator or a mode 0 zero numerator the result follows accept
// without iteration; otherwise the euclid loop runs one shift-subtract divide per
// remainder step, followed by the quotient divides and, in mode 1, the shift-add
// multiplies
// throughput: one transaction at a time, start taken only while busy is low
// reset: synchronous active-low i_rst_n returns the controller to idle; the result
// strobe lasts one cycle and the receiver cannot stall
module fraction_reduce_common_denominator #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_mode,
    input  logic signed [frcd_pkg::FieldW-1:0] i_num_a,
    input  logic signed [frcd_pkg::FieldW-1:0] i_den_a,
    input  logic signed [frcd_pkg::FieldW-1:0] i_num_b,
    input  logic signed [frcd_pkg::FieldW-1:0] i_den_b,
    output logic                               o_strobe,
    output logic signed [frcd_pkg::FieldW-1:0] o_out_num_a,
    output logic [frcd_pkg::DenOutW-1:0]       o_out_den_a,
    output logic signed [frcd_pkg::FieldW-1:0] o_out_num_b,
    output logic [frcd_pkg::DenOutW-1:0]       o_out_den_b,
    output logic [frcd_pkg::StatusW-1:0]       o_status
);

    frcd_pkg::t_cmd  w_cmd;
    frcd_pkg::t_stat w_stat;

    frcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    frcd_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_mode      (i_mode),
        .i_num_a     (i_num_a),
        .i_den_a     (i_den_a),
        .i_num_b     (i_num_b),
        .i_den_b     (i_den_b),
        .o_done      (o_strobe),
        .o_out_num_a (o_out_num_a),
        .o_out_den_a (o_out_den_a),
        .o_out_num_b (o_out_num_b),
        .o_out_den_b (o_out_den_b),
        .o_status    (o_status)
    );

endmodule
